[rtl/fdr_pkg.sv]
// fdr_pkg: shared types, constants and register indexes for the fdr threshold unit
// no dependencies
package fdr_pkg;

    localparam int DEF_MAX_COUNT = 64;
    localparam int DEF_FRAC_BITS = 16;

    localparam int P_W    = 16;
    localparam int POS_W  = 6;
    localparam int RANK_W = 7;
    localparam int IDX_W  = 2;

    localparam logic [P_W-1:0] ONE_P   = 16'hFFFF;
    localparam logic [P_W-1:0] Q_RESET = 16'd3277;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_Q_LEVEL      = 2'd0;
    localparam logic [IDX_W-1:0] REG_CONSERVATIVE = 2'd1;
    localparam logic [IDX_W-1:0] REG_ONE_MINUS_P  = 2'd2;

    // contents of one sort cell
    typedef struct packed {
        logic             valid;
        logic [P_W-1:0]   val;
        logic [POS_W-1:0] org;
    } cell_t;

    // chain control
    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctl_t;

endpackage

[rtl/fdr_if.sv]
// fdr_in_if, fdr_out_if: valid/ready channels of the fdr threshold unit
// depends on fdr_pkg
interface fdr_in_if;
    logic                       valid;
    logic                       ready;
    logic [fdr_pkg::P_W-1:0]    p_value;
    logic                       last_item;

    modport source (output valid, p_value, last_item, input ready);
    modport sink (input valid, p_value, last_item, output ready);
endinterface

interface fdr_out_if;
    logic                        valid;
    logic                        ready;
    logic [fdr_pkg::POS_W-1:0]   position;
    logic [fdr_pkg::RANK_W-1:0]  rank;
    logic [fdr_pkg::P_W-1:0]     adjusted_p;
    logic [fdr_pkg::P_W-1:0]     threshold;
    logic                        last_result;
    logic                        overflow;

    modport source (output valid, position, rank, adjusted_p, threshold, last_result,
                    overflow, input ready);
    modport sink (input valid, position, rank, adjusted_p, threshold, last_result,
                  overflow, output ready);
endinterface

[rtl/fdr_cell.sv]
// fdr_cell: one cell of the descending insertion chain
// depends on fdr_pkg
module fdr_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fdr_pkg::cell_ctl_t         ctl,
    input  logic [fdr_pkg::P_W-1:0]    new_val,
    input  logic [fdr_pkg::POS_W-1:0]  new_org,
    input  fdr_pkg::cell_t             left,
    input  logic                       left_keep,
    input  fdr_pkg::cell_t             right,
    output fdr_pkg::cell_t             own,
    output logic                       keep
);
    logic                      valid_reg, valid_next;
    logic [fdr_pkg::P_W-1:0]   val_reg, val_next;
    logic [fdr_pkg::POS_W-1:0] org_reg, org_next;

    // strictly larger values stay ahead, so later equal values land in front
    assign keep = valid_reg && (val_reg > new_val);

    always_comb
    begin
        valid_next = valid_reg;
        val_next   = val_reg;
        org_next   = org_reg;
        if (ctl.ins && !keep)
        begin
            if (left_keep)
            begin
                valid_next = 1'b1;
                val_next   = new_val;
                org_next   = new_org;
            end
            else
            begin
                valid_next = left.valid;
                val_next   = left.val;
                org_next   = left.org;
            end
        end
        else if (ctl.shift)
        begin
            valid_next = right.valid;
            val_next   = right.val;
            org_next   = right.org;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        org_reg <= org_next;
    end

    assign own = '{valid: valid_reg, val: val_reg, org: org_reg};
endmodule

[rtl/fdr_divider.sv]
// fdr_divider: restoring divider, one quotient bit per cycle
// depends on fdr_pkg
module fdr_divider #(
    parameter int DW = 26
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DW-1:0]                 dividend,
    input  logic [fdr_pkg::RANK_W-1:0]    divisor,
    output logic                          done,
    output logic [DW-1:0]                 quotient
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]               quo_reg, quo_next;
    logic [fdr_pkg::RANK_W:0]    rem_reg, rem_next;
    logic [fdr_pkg::RANK_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [fdr_pkg::RANK_W+1:0]  trial;

    // shift in one dividend bit and try the subtract
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DW-1]} - {2'b00, den_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[fdr_pkg::RANK_W+1])
            begin
                rem_next = trial[fdr_pkg::RANK_W:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[fdr_pkg::RANK_W-1:0], quo_reg[DW-1]};
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

[rtl/fdr_threshold_adjust_unit.sv]
// fdr_threshold_adjust_unit: benjamini-hochberg threshold and adjusted p-values
// depends on fdr_pkg, fdr_if, fdr_cell, fdr_divider
//
// Values load one per cycle into a chain of cells kept in descending order
// (ties: earlier arrival ranks lower). On the word marked last the chain is
// drained from the top rank down; each rank passes two multiply states, a
// divider start state, a serial divide (the quotient width does not depend
// on FRAC_BITS) and a store as the divide completes. Results then leave in
// arrival order from a small result memory, each word read, registered and
// held until the sink takes it. New words are accepted again after the last
// result of the set has been taken.
module fdr_threshold_adjust_unit #(
    parameter int MAX_COUNT = fdr_pkg::DEF_MAX_COUNT,
    parameter int FRAC_BITS = fdr_pkg::DEF_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fdr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [fdr_pkg::P_W-1:0]     cfg_data,
    fdr_in_if.sink                      in,
    fdr_out_if.source                   out
);
    localparam int CW  = $clog2(MAX_COUNT + 1);
    localparam int AW  = $clog2(MAX_COUNT);
    localparam int HW  = FRAC_BITS + 3;
    localparam int P1W = fdr_pkg::P_W + HW;
    localparam int NW  = P1W + fdr_pkg::RANK_W;
    localparam int DW  = NW - FRAC_BITS;
    localparam int QKW = fdr_pkg::P_W + fdr_pkg::RANK_W;
    localparam int MW  = fdr_pkg::RANK_W + fdr_pkg::P_W;
    localparam logic [HW-1:0] ONE_FIX = HW'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2, S_DIV, S_WAIT, S_RD, S_RDW, S_HOLD
    } state_t;

    state_t state_reg;

    // configuration
    logic [fdr_pkg::P_W-1:0] q_level_reg;
    logic                    conservative_reg;
    logic                    one_minus_p_reg;

    // set state
    logic [CW-1:0]               count_reg;
    logic                        dropped_reg;
    logic [HW-1:0]               harm_reg;
    logic [fdr_pkg::P_W-1:0]     thr_reg;
    logic [CW-1:0]               rank_reg;
    logic [fdr_pkg::P_W-1:0]     v_reg;
    logic [fdr_pkg::POS_W-1:0]   org_reg;
    logic [P1W-1:0]              prod1_reg;
    logic [NW-1:0]               num_reg;
    logic [QKW-1:0]              qk_reg;
    logic [fdr_pkg::P_W-1:0]     prev_reg;
    logic [CW-1:0]               emit_reg;

    // output word
    logic                        out_valid_reg;
    logic [fdr_pkg::POS_W-1:0]   pos_reg;
    logic [fdr_pkg::RANK_W-1:0]  orank_reg;
    logic [fdr_pkg::P_W-1:0]     adj_reg;
    logic                        olast_reg;

    // result memory addressed by arrival index
    logic [MW-1:0]               res_mem [MAX_COUNT];
    logic [MW-1:0]               rd_data_reg;
    logic                        mem_we;

    // harmonic increments floor(2^F/n)
    logic [HW-1:0]               recip [MAX_COUNT + 1];

    genvar gn;
    generate
        for (gn = 0; gn <= MAX_COUNT; gn++)
        begin : g_recip
            localparam int RV = (1 << FRAC_BITS) / ((gn == 0) ? 1 : gn);
            assign recip[gn] = HW'(RV);
        end
    endgenerate

    // chain of cells
    fdr_pkg::cell_t     cells [MAX_COUNT];
    logic               keeps [MAX_COUNT];
    fdr_pkg::cell_ctl_t ctl;
    logic [fdr_pkg::P_W-1:0] in_val;
    logic               accept;
    logic               load;

    assign in.ready = (state_reg == S_IDLE);
    assign accept   = in.valid && in.ready;
    assign load     = accept && (count_reg < CW'(MAX_COUNT));
    assign in_val   = one_minus_p_reg ? (fdr_pkg::ONE_P - in.p_value) : in.p_value;
    assign ctl.ins   = load;
    assign ctl.shift = (state_reg == S_MUL1);

    generate
        for (gn = 0; gn < MAX_COUNT; gn++)
        begin : g_cell
            fdr_pkg::cell_t left_c, right_c;
            logic           left_k;
            if (gn == 0)
            begin : g_first
                assign left_c = '0;
                assign left_k = 1'b1;
            end
            else
            begin : g_mid
                assign left_c = cells[gn-1];
                assign left_k = keeps[gn-1];
            end
            if (gn == MAX_COUNT - 1)
            begin : g_end
                assign right_c = '0;
            end
            else
            begin : g_nxt
                assign right_c = cells[gn+1];
            end
            fdr_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .new_val   (in_val),
                .new_org   (fdr_pkg::POS_W'(count_reg)),
                .left      (left_c),
                .left_keep (left_k),
                .right     (right_c),
                .own       (cells[gn]),
                .keep      (keeps[gn])
            );
        end
    endgenerate

    // divider for p*C*N / rank
    logic          div_start;
    logic          div_done;
    logic [DW-1:0] div_quo;

    assign div_start = (state_reg == S_DIV);

    fdr_divider #(.DW(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg[NW-1:FRAC_BITS]),
        .divisor  (fdr_pkg::RANK_W'(rank_reg)),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic [HW-1:0]           cfix;
    logic [fdr_pkg::P_W-1:0] sat_adj;
    logic [fdr_pkg::P_W-1:0] new_adj;
    logic [NW-1:0]           rhs;

    assign cfix    = conservative_reg ? harm_reg : ONE_FIX;
    assign sat_adj = (div_quo > DW'(fdr_pkg::ONE_P)) ? fdr_pkg::ONE_P
                                                     : div_quo[fdr_pkg::P_W-1:0];
    assign new_adj = (sat_adj > prev_reg) ? prev_reg : sat_adj;
    assign rhs     = NW'(qk_reg) << FRAC_BITS;
    assign mem_we  = (state_reg == S_WAIT) && div_done;

    // result memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            res_mem[org_reg[AW-1:0]] <= {fdr_pkg::RANK_W'(rank_reg), new_adj};
        rd_data_reg <= res_mem[emit_reg[AW-1:0]];
    end

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            q_level_reg      <= fdr_pkg::Q_RESET;
            conservative_reg <= 1'b0;
            one_minus_p_reg  <= 1'b0;
            count_reg        <= '0;
            dropped_reg      <= 1'b0;
            harm_reg         <= ONE_FIX;
            thr_reg          <= '0;
            rank_reg         <= '0;
            prev_reg         <= fdr_pkg::ONE_P;
            emit_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fdr_pkg::REG_Q_LEVEL:      q_level_reg      <= cfg_data;
                    fdr_pkg::REG_CONSERVATIVE: conservative_reg <= cfg_data[0];
                    fdr_pkg::REG_ONE_MINUS_P:  one_minus_p_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (load)
                        begin
                            count_reg <= count_reg + 1'b1;
                            if (count_reg != '0)
                                harm_reg <= harm_reg + recip[count_reg + 1'b1];
                            rank_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                            rank_reg    <= count_reg;
                        end
                        if (in.last_item)
                        begin
                            thr_reg   <= '0;
                            prev_reg  <= fdr_pkg::ONE_P;
                            state_reg <= S_MUL1;
                        end
                    end
                end
                // top cell leaves the chain
                S_MUL1:
                begin
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if ((v_reg > thr_reg) && (num_reg <= rhs))
                        thr_reg <= v_reg;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        prev_reg <= new_adj;
                        rank_reg <= rank_reg - 1'b1;
                        if (rank_reg == CW'(1))
                        begin
                            emit_reg  <= '0;
                            state_reg <= S_RD;
                        end
                        else
                            state_reg <= S_MUL1;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_RDW;
                end
                S_RDW:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_HOLD;
                end
                S_HOLD:
                begin
                    if (out.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        emit_reg      <= emit_reg + 1'b1;
                        if (olast_reg)
                        begin
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                            harm_reg    <= ONE_FIX;
                            state_reg   <= S_IDLE;
                        end
                        else
                            state_reg <= S_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL1)
        begin
            v_reg     <= cells[0].val;
            org_reg   <= cells[0].org;
            prod1_reg <= P1W'(cells[0].val) * P1W'(cfix);
        end
        if (state_reg == S_MUL2)
        begin
            num_reg <= NW'(prod1_reg) * NW'(count_reg);
            qk_reg  <= QKW'(q_level_reg) * QKW'(rank_reg);
        end
        if (state_reg == S_RDW)
        begin
            pos_reg   <= fdr_pkg::POS_W'(emit_reg);
            orank_reg <= rd_data_reg[MW-1:fdr_pkg::P_W];
            adj_reg   <= one_minus_p_reg ? (fdr_pkg::ONE_P - rd_data_reg[fdr_pkg::P_W-1:0])
                                         : rd_data_reg[fdr_pkg::P_W-1:0];
            olast_reg <= (emit_reg == count_reg - 1'b1);
        end
    end

    assign out.valid       = out_valid_reg;
    assign out.position    = pos_reg;
    assign out.rank        = orank_reg;
    assign out.adjusted_p  = adj_reg;
    assign out.threshold   = thr_reg;
    assign out.last_result = olast_reg;
    assign out.overflow    = dropped_reg;

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in.ready && out.valid))
        else $error("input taken while a result is pending");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_COUNT))
        else $error("item count beyond capacity");
    a_rank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> (out.rank != '0))
        else $error("result with zero rank");
    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && out.ready && out.last_result) |=> (count_reg == '0))
        else $error("set not cleared after last result");
endmodule

[dv/testbench.sv]
// testbench: self-checking bench for fdr_threshold_adjust_unit (benjamini-hochberg fdr)
// depends on fdr_pkg, fdr_in_if, fdr_out_if and the unit itself
// a clocked driver and monitor with random idling; a built-in predictor checks every result word
module testbench;

    localparam int CAP = fdr_pkg::DEF_MAX_COUNT;
    localparam int FB  = fdr_pkg::DEF_FRAC_BITS;
    localparam int PW  = fdr_pkg::P_W;

    typedef struct {
        logic [fdr_pkg::P_W-1:0] p;
        logic                    last;
    } p_word_t;

    typedef struct {
        logic [fdr_pkg::POS_W-1:0]  position;
        logic [fdr_pkg::RANK_W-1:0] rank;
        logic [fdr_pkg::P_W-1:0]    adjusted_p;
        logic [fdr_pkg::P_W-1:0]    threshold;
        logic                       last_result;
        logic                       overflow;
    } fdr_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [fdr_pkg::IDX_W-1:0] cfg_index;
    logic [fdr_pkg::P_W-1:0] cfg_data;

    fdr_in_if  in_ch ();
    fdr_out_if out_ch ();

    fdr_threshold_adjust_unit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in(in_ch.sink), .out(out_ch.source)
    );

    p_word_t     pending_words[$];
    fdr_result_t expected_results[$];
    int in_idle_pct;
    int out_idle_pct;
    int mismatches;
    int words_sent;
    int results_seen;
    int sets_sent;

    // shadow of the configuration registers
    logic [fdr_pkg::P_W-1:0] q_shadow;
    logic                    cons_shadow;
    logic                    invert_shadow;

    // shadow of the sorted store and set bookkeeping
    logic [fdr_pkg::P_W-1:0]   sorted_p[CAP];
    logic [fdr_pkg::POS_W-1:0] sorted_org[CAP];
    int                        set_count;
    logic                      set_dropped;
    longint unsigned           harm_sum;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // load one word into the shadow store; on the last word compute the set's results
    function automatic void predict_word(logic [fdr_pkg::P_W-1:0] p_in, logic last);
        logic [fdr_pkg::P_W-1:0] v;
        logic [fdr_pkg::P_W-1:0] adj_store[CAP];
        int rank_of[CAP];
        int at;
        int n;
        longint unsigned cfix;
        longint unsigned lhs;
        longint unsigned rhs;
        longint unsigned a;
        longint unsigned prev;
        logic [fdr_pkg::P_W-1:0] thr;
        fdr_result_t r;
        v = invert_shadow ? fdr_pkg::ONE_P - p_in : p_in;
        if (set_count >= CAP)
            set_dropped = 1'b1;
        else
        begin
            at = set_count;
            while (at > 0 && sorted_p[at-1] > v)
            begin
                sorted_p[at] = sorted_p[at-1];
                sorted_org[at] = sorted_org[at-1];
                at--;
            end
            sorted_p[at] = v;
            sorted_org[at] = set_count[fdr_pkg::POS_W-1:0];
            set_count++;
            if (set_count >= 2)
                harm_sum += (64'd1 << FB) / set_count;
        end
        if (!last)
            return;
        n = set_count;
        cfix = cons_shadow ? harm_sum : (64'd1 << FB);
        thr = '0;
        for (int k = 0; k < n; k++)
        begin
            lhs = longint'(sorted_p[k]) * cfix * n;
            rhs = (longint'(q_shadow) * (k + 1)) << FB;
            if (sorted_p[k] > thr && lhs <= rhs)
                thr = sorted_p[k];
            rank_of[sorted_org[k]] = k + 1;
        end
        prev = 64'(fdr_pkg::ONE_P);
        for (int k = n; k >= 1; k--)
        begin
            a = (longint'(sorted_p[k-1]) * cfix * n) / (longint'(k) << FB);
            if (a > 64'(fdr_pkg::ONE_P))
                a = 64'(fdr_pkg::ONE_P);
            if (a > prev)
                a = prev;
            prev = a;
            adj_store[k-1] = a[fdr_pkg::P_W-1:0];
        end
        for (int k = 0; k < n; k++)
        begin
            r.position = k[fdr_pkg::POS_W-1:0];
            r.rank = rank_of[k][fdr_pkg::RANK_W-1:0];
            r.adjusted_p = invert_shadow ? fdr_pkg::ONE_P - adj_store[rank_of[k]-1]
                                         : adj_store[rank_of[k]-1];
            r.threshold = thr;
            r.last_result = (k + 1 == n);
            r.overflow = set_dropped;
            expected_results.push_back(r);
        end
        set_count = 0;
        set_dropped = 1'b0;
        harm_sum = 64'd1 << FB;
        sets_sent++;
    endfunction

    // driver: present the next pending word, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        p_word_t w;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.p_value <= '0;
            in_ch.last_item <= 1'b0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid)
            begin
                predict_word(in_ch.p_value, in_ch.last_item);
                words_sent++;
            end
            if (pending_words.size() > 0 && $urandom_range(99) >= in_idle_pct)
            begin
                w = pending_words.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.p_value <= w.p;
                in_ch.last_item <= w.last;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor: take result words with random stalls and check them
    always @(posedge clk or negedge rst_n)
    begin
        fdr_result_t e;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: pos %0d rank %0d adj %0d",
                                 out_ch.position, out_ch.rank, out_ch.adjusted_p);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (out_ch.position !== e.position || out_ch.rank !== e.rank ||
                        out_ch.adjusted_p !== e.adjusted_p ||
                        out_ch.threshold !== e.threshold ||
                        out_ch.last_result !== e.last_result ||
                        out_ch.overflow !== e.overflow)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result mismatch: expected pos %0d rank %0d adj %0d thr %0d last %0b ovf %0b",
                                     e.position, e.rank, e.adjusted_p, e.threshold,
                                     e.last_result, e.overflow);
                            $display("                 got pos %0d rank %0d adj %0d thr %0d last %0b ovf %0b",
                                     out_ch.position, out_ch.rank, out_ch.adjusted_p,
                                     out_ch.threshold, out_ch.last_result, out_ch.overflow);
                        end
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // register write while the unit is idle
    task automatic write_reg(logic [fdr_pkg::IDX_W-1:0] idx, logic [fdr_pkg::P_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            fdr_pkg::REG_Q_LEVEL:      q_shadow = data;
            fdr_pkg::REG_CONSERVATIVE: cons_shadow = data[0];
            fdr_pkg::REG_ONE_MINUS_P:  invert_shadow = data[0];
            default:                   ;
        endcase
    endtask

    task automatic set_config(logic [fdr_pkg::P_W-1:0] q, logic cons, logic inv);
        write_reg(fdr_pkg::REG_Q_LEVEL, q);
        write_reg(fdr_pkg::REG_CONSERVATIVE, {15'd0, cons});
        write_reg(fdr_pkg::REG_ONE_MINUS_P, {15'd0, inv});
    endtask

    // hold off until all words are in and every result has come back, then let the unit settle
    task automatic drain();
        do @(negedge clk);
        while (pending_words.size() > 0 || in_ch.valid || expected_results.size() > 0);
        repeat (60) @(negedge clk);
    endtask

    function automatic void queue_word(logic [fdr_pkg::P_W-1:0] p, logic last);
        p_word_t w;
        w.p = p;
        w.last = last;
        pending_words.push_back(w);
    endfunction

    // one well-formed set of n words with mixed content: small values, ties, extremes
    function automatic void queue_random_set(int n);
        logic [fdr_pkg::P_W-1:0] p;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(5))
                0:       p = PW'($urandom_range(400));
                1:       p = PW'($urandom_range(4) * 100);
                2:       p = ($urandom_range(1) != 0) ? fdr_pkg::ONE_P : '0;
                3:       p = PW'($urandom_range(5000));
                default: p = PW'($urandom);
            endcase
            queue_word(p, i == n - 1);
        end
    endfunction

    function automatic void queue_random_batch(int words);
        int n;
        while (words > 0)
        begin
            n = ($urandom_range(19) == 0) ? int'($urandom_range(64, 20))
                                          : int'($urandom_range(8, 1));
            queue_random_set(n);
            words -= n;
        end
    endfunction

    // stimulus
    initial
    begin
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_idle_pct = 18;
        out_idle_pct = 64;
        mismatches = 0;
        words_sent = 0;
        results_seen = 0;
        sets_sent = 0;
        q_shadow = fdr_pkg::Q_RESET;
        cons_shadow = 1'b0;
        invert_shadow = 1'b0;
        set_count = 0;
        set_dropped = 1'b0;
        harm_sum = 64'd1 << FB;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single word, extremes, zeros, ties
        queue_word(16'd100, 1'b1);
        queue_word(fdr_pkg::ONE_P, 1'b0);
        queue_word(16'd0, 1'b0);
        queue_word(16'd1, 1'b0);
        queue_word(16'd0, 1'b0);
        queue_word(16'd50, 1'b0);
        queue_word(16'd50, 1'b1);
        queue_word(16'd0, 1'b1);
        drain();

        set_config(fdr_pkg::ONE_P, 1'b1, 1'b1);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'hFF00, 1'b0);
        queue_word(16'h0000, 1'b0);
        queue_word(16'hFFF0, 1'b0);
        queue_word(16'hAAAA, 1'b0);
        queue_word(16'h5555, 1'b1);
        queue_word(16'h8000, 1'b1);
        drain();

        // capacity: overflow set finished by a dropped word, then a set of exactly 64
        set_config(16'd3277, 1'b0, 1'b0);
        for (int i = 0; i < CAP + 2; i++)
            queue_word(PW'($urandom_range(3000)), i == CAP + 1);
        drain();
        queue_random_set(CAP);
        drain();

        // random: sender light, receiver heavy idling
        set_config(16'd0, 1'b1, 1'b0);
        queue_random_batch(22);
        drain();
        set_config(PW'($urandom), 1'b0, 1'b1);
        queue_random_batch(22);
        drain();

        // random: roles swapped
        in_idle_pct = 64;
        out_idle_pct = 18;
        set_config(fdr_pkg::ONE_P, 1'b0, 1'b0);
        queue_random_batch(22);
        drain();
        set_config(16'd6554, 1'b1, 1'b1);
        queue_random_batch(22);
        drain();

        // random: no idling either side
        in_idle_pct = 0;
        out_idle_pct = 0;
        set_config(PW'($urandom_range(20000)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
        queue_random_batch(22);
        drain();

        $display("covered %0d words in %0d sets, %0d result words checked,",
                 words_sent, sets_sent, results_seen);
        $display("across q extremes, conservative and inverted modes and an overflowed set");
        if (mismatches == 0)
            $display("fdr_threshold_adjust_unit verification clean");
        else
            $display("fdr_threshold_adjust_unit verification failed");
        $finish;
    end

    // timeout
    initial
    begin
        #40000000;
        $display("timeout with %0d result words outstanding", expected_results.size());
        $display("fdr_threshold_adjust_unit verification failed");
        $finish;
    end
endmodule

[filelist.f]
rtl/fdr_pkg.sv
rtl/fdr_if.sv
rtl/fdr_cell.sv
rtl/fdr_divider.sv
rtl/fdr_threshold_adjust_unit.sv
dv/testbench.sv
